// ===== rtl/xor_linear_basis_macros.svh =====
// assertion macros shared by the xor linear basis rtl
`ifndef XOR_LINEAR_BASIS_MACROS_SVH
`define XOR_LINEAR_BASIS_MACROS_SVH

// clocked check, off while reset is asserted
`define XLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define XLB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/xlb_pkg.sv =====
// package with shared types and constants for the xor linear basis
`timescale 1ns / 1ps

package xlb_pkg;

  // fixed field widths of the beats
  localparam int unsigned VEC_W  = 64;
  localparam int unsigned RANK_W = 7;

  // operation codes
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_CLR,
    ST_WR,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/xor_linear_basis.sv =====
// xor linear basis: gf(2) row-echelon basis with insert and span query
`timescale 1ns / 1ps
//
// Usage
// - input channel: in_valid_i / in_stall_o carry op_i and vec_i; op_i selects
//   insert (add vec_i to the basis) or query (span test only). Only the low
//   WIDTH bits of vec_i count.
// - output channel: out_valid_o / out_stall_i carry in_span_o and rank_o, one
//   result beat per input beat, in order.
// - sequence: a query or a dependent insert makes one reduction sweep of the
//   row memory before its result beat; an independent insert adds a sweep to
//   clear the new pivot from the other rows and a write of the new row.
// - throughput: one beat at a time; the next beat is taken only after the last
//   one's sweeps: one sweep of the row memory for the reduction and, for an
//   independent insert, a second sweep to clear the new pivot, one row per
//   cycle with the registered read one row ahead of the xor unit.
// - in_stall_o is high from accept until the result is placed in the output
//   register; a new beat can be taken while that result waits for the
//   receiver, and the next result then waits in its final state.
// - reset empties the basis at once (valid bits and row count clear) and drops
//   any pending result; no memory sweep is needed.
//
module xor_linear_basis
  import xlb_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [VEC_W-1:0]  vec_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              in_span_o,
  output logic [RANK_W-1:0] rank_o
);

`include "xor_linear_basis_macros.svh"

  localparam int unsigned IdxW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int unsigned CntW = $clog2(WIDTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WIDTH - 1);

  // row memory, indexed by pivot
  logic [WIDTH-1:0] mem [WIDTH];
  logic [WIDTH-1:0] rdata_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [WIDTH-1:0] mem_wdata;

  // sequencer state
  state_e           state_q, state_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic             op_q, op_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             issue_q, issue_d;
  logic             use_q, use_d;
  logic [IdxW-1:0]  use_idx_q, use_idx_d;
  logic [IdxW-1:0]  piv_q, piv_d;
  logic             found_q, found_d;
  logic             span_q, span_d;
  logic [WIDTH-1:0] row_valid_q, row_valid_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              in_span_q, in_span_d;
  logic [RANK_W-1:0] rank_q, rank_d;

  // xor unit signals
  logic             hit;
  logic [WIDTH-1:0] x_new;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_span_o   = in_span_q;
  assign rank_o      = rank_q;

  // shared xor unit: reduce step and clear step
  always_comb begin
    hit   = 1'b0;
    x_new = x_q;
    if (state_q == ST_RED) begin
      hit   = row_valid_q[use_idx_q] & x_q[use_idx_q];
      x_new = hit ? (x_q ^ rdata_q) : x_q;
    end else if (state_q == ST_CLR) begin
      hit = row_valid_q[use_idx_q] & rdata_q[piv_q];
    end
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    op_d        = op_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    use_d       = issue_q;
    use_idx_d   = idx_q;
    piv_d       = piv_q;
    found_d     = found_q;
    span_d      = span_q;
    row_valid_d = row_valid_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    in_span_d   = in_span_q;
    rank_d      = rank_q;
    mem_we      = 1'b0;
    mem_waddr   = use_idx_q;
    mem_wdata   = rdata_q ^ x_q;

    // output beat taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // read address walks ahead of the xor unit by one row
    if (issue_q) begin
      if (idx_q == LastIdx) begin
        issue_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        use_d   = 1'b0;
        issue_d = 1'b0;
        if (in_valid_i) begin
          x_d     = vec_i[WIDTH-1:0];
          op_d    = op_i;
          idx_d   = '0;
          issue_d = 1'b1;
          found_d = 1'b0;
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        if (use_q) begin
          x_d = x_new;
          // bit use_idx_q is final once its row has been applied
          if (!found_q && x_new[use_idx_q]) begin
            found_d = 1'b1;
            piv_d   = use_idx_q;
          end
          if (use_idx_q == LastIdx) begin
            span_d = (x_new == '0);
            if (op_q == OP_INSERT && x_new != '0) begin
              idx_d   = '0;
              issue_d = 1'b1;
              use_d   = 1'b0;
              state_d = ST_CLR;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_CLR: begin
        if (use_q) begin
          mem_we = hit;
          if (use_idx_q == LastIdx) begin
            state_d = ST_WR;
          end
        end
      end
      ST_WR: begin
        mem_we             = 1'b1;
        mem_waddr          = piv_q;
        mem_wdata          = x_q;
        row_valid_d[piv_q] = 1'b1;
        cnt_d              = cnt_q + CntW'(1);
        state_d            = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          in_span_d   = span_q;
          rank_d      = RANK_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      use_q       <= 1'b0;
      found_q     <= 1'b0;
      row_valid_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      use_q       <= use_d;
      found_q     <= found_d;
      row_valid_q <= row_valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    op_q      <= op_d;
    idx_q     <= idx_d;
    use_idx_q <= use_idx_d;
    piv_q     <= piv_d;
    span_q    <= span_d;
    in_span_q <= in_span_d;
    rank_q    <= rank_d;
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[idx_q];
  end

  // checks
  `XLB_ASSERT(a_accept_starts_reduce, (in_valid_i && !in_stall_o) |=> (state_q == ST_RED), "accepted beat did not start a reduction")
  `XLB_ASSERT(a_count_matches_valid, $countones(row_valid_q) == int'(cnt_q), "row count differs from number of valid rows")
  `XLB_ASSERT(a_clear_needs_pivot, (state_q == ST_CLR) |-> (found_q && op_q == OP_INSERT), "clear pass without a pivot on an insert")
  `XLB_ASSERT(a_new_row_free, (state_q == ST_WR) |-> !row_valid_q[piv_q], "new row written over a valid pivot")
  `XLB_ASSERT(a_result_not_lost, (out_valid_q && out_stall_i) |=> out_valid_q, "pending result dropped under stall")

endmodule
